### hdl/station_assoc_table_macros.svh
// Assertion macros used by the checker of the station table.
`ifndef STATION_ASSOC_TABLE_MACROS_SVH
`define STATION_ASSOC_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SAT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("station table assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define SAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("station table assertion failed");

`endif

### hdl/sat_pkg.sv
package sat_pkg;

  localparam int StationsDefault = 32;

  localparam int FuncW     = 2;
  localparam int AddrW     = 48;
  localparam int RateW     = 8;
  localparam int SigW      = 8;
  localparam int StatusW   = 2;
  localparam int SeqW      = 12;
  localparam int CountOutW = 6;

  localparam logic [StatusW-1:0] StAbsent = 2'd0;
  localparam logic [StatusW-1:0] StAuth   = 2'd1;
  localparam logic [StatusW-1:0] StAssoc  = 2'd2;

  typedef enum logic [FuncW-1:0] {
    OpAuth   = 2'd0,
    OpAssoc  = 2'd1,
    OpDelete = 2'd2,
    OpUpdate = 2'd3
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic                   take_seq;
    logic [AddrW-1:0]       addr;
    logic [RateW-1:0]       rate;
    logic signed [SigW-1:0] rx_signal;
  } cmd_t;

  typedef struct packed {
    logic [AddrW-1:0]       addr;
    logic [StatusW-1:0]     status;
    logic [RateW-1:0]       rate;
    logic signed [SigW-1:0] rx_signal;
  } entry_t;

  typedef struct packed {
    logic                 accepted;
    logic                 found;
    logic [StatusW-1:0]   status;
    logic [SeqW-1:0]      seq;
    logic                 full;
    logic [CountOutW-1:0] count;
  } res_t;

endpackage

### hdl/sat_front.sv
module sat_front import sat_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [FuncW-1:0]       func_i,
  input  logic [AddrW-1:0]       station_addr_i,
  input  logic [RateW-1:0]       rx_rate_i,
  input  logic signed [SigW-1:0] rx_signal_i,
  output logic                   q_valid_o,
  output cmd_t                   q_cmd_o,
  input  logic                   q_pop_i
);

  localparam int Depth = 2;

  cmd_t       fifo_q [Depth];
  cmd_t       cmd_d;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  always_comb begin
    cmd_d.op        = op_e'(func_i);
    cmd_d.take_seq  = (cmd_d.op inside {OpAuth, OpAssoc});
    cmd_d.addr      = station_addr_i;
    cmd_d.rate      = rx_rate_i;
    cmd_d.rx_signal = rx_signal_i;
  end

  assign in_stall_o = (cnt_q == 2'(Depth));
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = fifo_q[rd_ptr_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_d;
    end
  end

endmodule

### hdl/sat_back.sv
module sat_back import sat_pkg::*; #(
  parameter int STATIONS = StationsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  cmd_t                 q_cmd_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 accepted_o,
  output logic                 station_found_o,
  output logic [StatusW-1:0]   station_status_o,
  output logic [SeqW-1:0]      seq_number_o,
  output logic                 table_full_o,
  output logic [CountOutW-1:0] station_count_o
);

  localparam int IdxW = $clog2(STATIONS);
  localparam int CntW = $clog2(STATIONS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(STATIONS - 1);

  typedef enum logic [1:0] {
    SIdle,
    SScan,
    SExec
  } state_e;

  state_e              state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [IdxW-1:0]     scan_idx_q, scan_idx_d;
  logic                hit_q, hit_d;
  logic [IdxW-1:0]     hit_idx_q, hit_idx_d;
  entry_t              hit_entry_q, hit_entry_d;
  logic                free_found_q, free_found_d;
  logic [IdxW-1:0]     free_idx_q, free_idx_d;
  logic [STATIONS-1:0] valid_q, valid_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [SeqW-1:0]     seq_q, seq_d;
  logic                out_valid_q, out_valid_d;
  res_t                res_q, res_d;

  entry_t              mem [STATIONS];
  entry_t              rdata_q;
  logic [IdxW-1:0]     rd_addr;
  logic                we;
  logic [IdxW-1:0]     wa;
  entry_t              wd;

  logic                cur_hit;
  logic                cur_free;

  assign cur_hit  = valid_q[scan_idx_q] && (rdata_q.addr == cmd_q.addr);
  assign cur_free = !valid_q[scan_idx_q];

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    scan_idx_d   = scan_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_entry_d  = hit_entry_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    valid_d      = valid_q;
    count_d      = count_q;
    seq_d        = seq_q;
    out_valid_d  = out_valid_q && out_stall_i;
    res_d        = res_q;
    q_pop_o      = 1'b0;
    rd_addr      = '0;
    we           = 1'b0;
    wa           = hit_idx_q;
    wd           = hit_entry_q;

    case (state_q)
      SIdle: begin
        if (q_valid_i) begin
          q_pop_o      = 1'b1;
          cmd_d        = q_cmd_i;
          scan_idx_d   = '0;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
          state_d      = SScan;
        end
      end
      SScan: begin
        rd_addr = (scan_idx_q == LastIdx) ? '0 : scan_idx_q + IdxW'(1);
        if (cur_free && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = scan_idx_q;
        end
        if (cur_hit) begin
          hit_d       = 1'b1;
          hit_idx_d   = scan_idx_q;
          hit_entry_d = rdata_q;
          state_d     = SExec;
        end else if (scan_idx_q == LastIdx) begin
          state_d = SExec;
        end else begin
          scan_idx_d = scan_idx_q + IdxW'(1);
        end
      end
      SExec: begin
        if (!out_valid_q || !out_stall_i) begin
          res_d.accepted = 1'b0;
          res_d.found    = hit_q;
          res_d.status   = hit_q ? hit_entry_q.status : StAbsent;
          res_d.seq      = '0;
          res_d.full     = 1'b0;
          case (cmd_q.op)
            OpAuth: begin
              if (hit_q) begin
                we             = 1'b1;
                wd.status      = StAuth;
                res_d.accepted = 1'b1;
                res_d.status   = StAuth;
              end else if (free_found_q) begin
                we                  = 1'b1;
                wa                  = free_idx_q;
                wd.addr             = cmd_q.addr;
                wd.status           = StAuth;
                wd.rate             = '0;
                wd.rx_signal        = '0;
                valid_d[free_idx_q] = 1'b1;
                count_d             = count_q + CntW'(1);
                res_d.accepted      = 1'b1;
                res_d.status        = StAuth;
              end else begin
                res_d.full   = 1'b1;
                res_d.status = StAbsent;
              end
            end
            OpAssoc: begin
              if (hit_q && (hit_entry_q.status != StAbsent)) begin
                we             = 1'b1;
                wd.status      = StAssoc;
                res_d.accepted = 1'b1;
                res_d.status   = StAssoc;
              end
            end
            OpDelete: begin
              if (hit_q) begin
                valid_d[hit_idx_q] = 1'b0;
                if (count_q != '0) begin
                  count_d = count_q - CntW'(1);
                end
                res_d.accepted = 1'b1;
              end
              res_d.status = StAbsent;
            end
            OpUpdate: begin
              if (hit_q) begin
                we             = 1'b1;
                wd.rate        = cmd_q.rate;
                wd.rx_signal   = cmd_q.rx_signal;
                res_d.accepted = 1'b1;
              end
            end
            default: begin
              res_d.accepted = 1'b0;
            end
          endcase
          if (cmd_q.take_seq) begin
            res_d.seq = seq_q;
            seq_d     = seq_q + SeqW'(1);
          end
          res_d.count = CountOutW'(count_d);
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      cmd_q        <= '0;
      scan_idx_q   <= '0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      hit_entry_q  <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      valid_q      <= '0;
      count_q      <= '0;
      seq_q        <= '0;
      out_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      scan_idx_q   <= scan_idx_d;
      hit_q        <= hit_d;
      hit_idx_q    <= hit_idx_d;
      hit_entry_q  <= hit_entry_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      valid_q      <= valid_d;
      count_q      <= count_d;
      seq_q        <= seq_d;
      out_valid_q  <= out_valid_d;
      res_q        <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[rd_addr];
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = res_q.accepted;
  assign station_found_o  = res_q.found;
  assign station_status_o = res_q.status;
  assign seq_number_o     = res_q.seq;
  assign table_full_o     = res_q.full;
  assign station_count_o  = res_q.count;

endmodule

### hdl/station_assoc_table.sv
// Channel | Direction | Handshake             | Beat payload
// in      | input     | in_valid_i/in_stall_o | func, station_addr, rx_rate, rx_signal
// out     | output    | out_valid_o/out_stall_i | accepted, station_found, station_status,
//         |           |                       |   seq_number, table_full, station_count
//
// One operation pops the command queue, scans the addresses over the single-read-port
// table memory one entry at a time (stops at the first match), and then ends in write-back.
// A two-beat command queue keeps accepting while the scan runs, until it is full.
// Reset clears valid bits, station count and sequence counter; no clearing pass.
// A stalled result holds the table in write-back; commands queue until it drains.
module station_assoc_table import sat_pkg::*; #(
  parameter int STATIONS = StationsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [FuncW-1:0]       func_i,
  input  logic [AddrW-1:0]       station_addr_i,
  input  logic [RateW-1:0]       rx_rate_i,
  input  logic signed [SigW-1:0] rx_signal_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   accepted_o,
  output logic                   station_found_o,
  output logic [StatusW-1:0]     station_status_o,
  output logic [SeqW-1:0]        seq_number_o,
  output logic                   table_full_o,
  output logic [CountOutW-1:0]   station_count_o
);

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  sat_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .station_addr_i (station_addr_i),
    .rx_rate_i      (rx_rate_i),
    .rx_signal_i    (rx_signal_i),
    .q_valid_o      (q_valid),
    .q_cmd_o        (q_cmd),
    .q_pop_i        (q_pop)
  );

  sat_back #(
    .STATIONS (STATIONS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_cmd_i          (q_cmd),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_o       (accepted_o),
    .station_found_o  (station_found_o),
    .station_status_o (station_status_o),
    .seq_number_o     (seq_number_o),
    .table_full_o     (table_full_o),
    .station_count_o  (station_count_o)
  );

endmodule

### hdl/sat_checker.sv
`include "station_assoc_table_macros.svh"

module sat_checker import sat_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               accepted_o,
  input logic               station_found_o,
  input logic [StatusW-1:0] station_status_o,
  input logic               table_full_o
);

  `SAT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `SAT_ASSERT_NOW(a_full_reject, out_valid_o && table_full_o, !accepted_o && !station_found_o && (station_status_o == StAbsent))
  `SAT_ASSERT_NOW(a_new_is_auth, out_valid_o && accepted_o && !station_found_o, (station_status_o == StAuth) && !table_full_o)
  `SAT_ASSERT_NOW(a_assoc_known, out_valid_o && accepted_o && (station_status_o == StAssoc), station_found_o)

endmodule

bind station_assoc_table sat_checker u_checker (.*);
